// ===== hdl/dpfrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpfrc_pkg
// Shared types, sizes and op codes for the dedup packet FIFO with range count.
// ----------------------------------------------------------------------------
package dpfrc_pkg;

    // Number of cells in the packet chain.
    localparam int DEPTH      = 64;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W      = $clog2(GROUP_SIZE + 1);

    localparam int LIMIT_W    = 7;
    localparam int MATCH_W    = 7;

    typedef logic [1:0]  op_t;
    typedef logic [63:0] word_t;   // {source, destination, timestamp}

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_FWD = 2'd1;
    localparam op_t OP_CNT = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } cmd_beat_t;

    typedef struct packed {
        logic               accepted;
        logic               packet_valid;
        logic [15:0]        out_source;
        logic [15:0]        out_destination;
        logic [31:0]        out_timestamp;
        logic [MATCH_W-1:0] match_count;
    } rsp_beat_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic valid;   // cell holds a live packet
        logic shift;   // take the younger neighbor's packet
        logic load;    // take the command's packet
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/dpfrc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpfrc_cell
// One FIFO slot: holds a packet, shifts toward the head, flags a key match.
// ----------------------------------------------------------------------------
module dpfrc_cell
    import dpfrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire cmd_beat_t  key,
    input  wire word_t      younger,
    output      word_t      word,
    output      logic       hit
);

    word_t word_reg;
    word_t word_next;
    logic  hit_reg;
    logic  hit_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            word_next = {key.source, key.destination, key.timestamp};
        end
        else if (ctrl.shift)
        begin
            word_next = younger;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // Exact triple match for add; destination and window match for count.
    always_comb
    begin
        if (key.op == OP_ADD)
        begin
            hit_next = ctrl.valid
                && (word_reg == {key.source, key.destination, key.timestamp});
        end
        else
        begin
            hit_next = ctrl.valid
                && (word_reg[47:32] == key.destination)
                && (word_reg[31:0] >= key.start_time)
                && (word_reg[31:0] <= key.end_time);
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule
`default_nettype wire

// ===== hdl/dpfrc_count.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpfrc_count
// Two-level hit counter: registered group sums, then a final add.
// ----------------------------------------------------------------------------
module dpfrc_count
    import dpfrc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [DEPTH-1:0] hits,
    output      logic [CNT_W-1:0] total
);

    logic [NUM_GROUPS*GROUP_SIZE-1:0] hits_pad;
    logic [GRP_W-1:0]                 group_reg  [NUM_GROUPS];
    logic [GRP_W-1:0]                 group_next [NUM_GROUPS];

    always_comb
    begin
        hits_pad            = '0;
        hits_pad[DEPTH-1:0] = hits;
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                group_next[g] = group_next[g]
                    + GRP_W'(hits_pad[g*GROUP_SIZE + b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_reg[g] <= group_next[g];
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            total = total + CNT_W'(group_reg[g]);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dedup_packet_fifo_with_range_count.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count
// Bounded packet FIFO with duplicate filter and destination/time range count.
// ----------------------------------------------------------------------------
//  channel   signals                    direction  handshake
//  command   start, busy, cmd           in         start & !busy takes a beat
//  result    done, result               out        done marks a one-cycle beat
//  config    cfg_we, cfg_data           in         written on any clock edge with cfg_we high
//
//  Each command passes through the accept edge, cell compare, group count,
//  then the chain update and result register; done is high the cycle after.
//  busy is low again in the cycle done is high, so a new command may be
//  taken then. Reset (rst_n, async low) empties the FIFO and sets the limit
//  to 64; cell contents are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count
    import dpfrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire cmd_beat_t          cmd,
    output      logic               done,
    output      rsp_beat_t          result,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;   // cells compare against the key
    localparam logic [1:0] ST_SUM  = 2'd2;   // group sums register
    localparam logic [1:0] ST_FIN  = 2'd3;   // chain update, result out

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    cmd_beat_t          cmd_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;
    logic [LIMIT_W-1:0] limit_reg;
    rsp_beat_t          result_reg;
    rsp_beat_t          result_next;
    logic               done_reg;
    logic               done_next;

    // Chain wiring
    word_t              words [DEPTH];
    logic [DEPTH-1:0]   hits;
    logic [CNT_W-1:0]   total;
    cell_ctrl_t         ctrl  [DEPTH];

    // FIN-cycle decisions
    logic               do_shift;
    logic               do_load;
    logic [CNT_W-1:0]   lim_eff;
    logic               evict;
    logic [CNT_W-1:0]   wr_pos;
    logic [IDX_W-1:0]   wr_idx;

    // ------------------------------------------------------------------
    // Effective limit: clamp the register into 1..DEPTH.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = CNT_W'(1);
        end
        else if (32'(limit_reg) > 32'(DEPTH))
        begin
            lim_eff = CNT_W'(DEPTH);
        end
        else
        begin
            lim_eff = CNT_W'(limit_reg);
        end
    end

    // Full (or over a lowered limit): drop the oldest, occupancy holds.
    assign evict  = (occ_reg >= lim_eff);
    assign wr_pos = evict ? (occ_reg - CNT_W'(1)) : occ_reg;
    assign wr_idx = wr_pos[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer and result formation
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        result_next = '0;
        done_next   = 1'b0;
        do_shift    = 1'b0;
        do_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (cmd_reg.op)
                    OP_ADD:
                    begin
                        // any hit among live cells means a duplicate
                        if (total == '0)
                        begin
                            result_next.accepted = 1'b1;
                            do_load              = 1'b1;
                            do_shift             = evict;
                            occ_next = evict ? occ_reg : (occ_reg + CNT_W'(1));
                        end
                    end
                    OP_FWD:
                    begin
                        if (occ_reg != '0)
                        begin
                            result_next.packet_valid    = 1'b1;
                            result_next.out_source      = words[0][63:48];
                            result_next.out_destination = words[0][47:32];
                            result_next.out_timestamp   = words[0][31:0];
                            do_shift                    = 1'b1;
                            occ_next                    = occ_reg - CNT_W'(1);
                        end
                    end
                    OP_CNT:
                    begin
                        result_next.match_count = MATCH_W'(total);
                    end
                    default:
                    begin
                        // unused op: no state change, zero result
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            limit_reg <= LIMIT_W'(64);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 holds the oldest packet, shifts move toward it.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t younger;

        if (i < DEPTH - 1)
        begin : g_mid
            assign younger = words[i+1];
        end
        else
        begin : g_last
            assign younger = '0;
        end

        assign ctrl[i].valid = (CNT_W'(i) < occ_reg);
        assign ctrl[i].shift = do_shift;
        assign ctrl[i].load  = do_load && (wr_idx == IDX_W'(i));

        dpfrc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[i]),
            .key     (cmd_reg),
            .younger (younger),
            .word    (words[i]),
            .hit     (hits[i])
        );
    end

    dpfrc_count u_count (
        .clk   (clk),
        .hits  (hits),
        .total (total)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("result beat missing at end of command");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above chain depth");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.accepted && result.packet_valid))
        else $error("add and forward flags both set");

endmodule
`default_nettype wire
